// ----- rtl/mexp_pkg.sv -----
// Package with widths, operation codes and controller/datapath interface types.
`default_nettype none
package mexp_pkg;

    localparam int WORD_BITS    = 63;
    localparam int CNT_BITS     = $clog2(WORD_BITS);
    localparam int IN_TDATA_W   = ((3 * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((WORD_BITS + 7) / 8) * 8;
    localparam int SUM_BITS     = WORD_BITS + 2;

    localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(WORD_BITS - 1);

    // Operand selection for the shared modular multiplier.
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_MUL,
        OP_SQUARE
    } t_op;

    // What the accumulator register takes.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_ONE,
        ACC_ZERO,
        ACC_INIT,
        ACC_PROD
    } t_acc_sel;

    typedef struct packed {
        logic     load;
        logic     start;
        t_op      op;
        logic     step;
        logic     wr_base;
        t_acc_sel acc_sel;
        logic     shift_exp;
        logic     set_res;
    } t_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic mod_zero;
        logic mul_last;
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/mexp_datapath.sv -----
// Datapath: operand registers, bit-serial modular multiplier and result register.
`default_nettype none
module mexp_datapath (
    input  wire logic                                i_clk,
    input  wire mexp_pkg::t_cmd                      i_cmd,
    output mexp_pkg::t_status                        o_status,
    input  wire logic [mexp_pkg::IN_TDATA_W-1:0]     i_in_data,
    output logic      [mexp_pkg::WORD_BITS-1:0]      o_res
);

    localparam int W = mexp_pkg::WORD_BITS;
    localparam int S = mexp_pkg::SUM_BITS;

    logic [W-1:0] r_base;
    logic [W-1:0] r_exp;
    logic [W-1:0] r_mod;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_prod;
    logic [W-1:0] r_mcand;
    logic [W-1:0] r_mult;
    logic [W-1:0] r_res;
    logic [mexp_pkg::CNT_BITS-1:0] r_cnt;

    logic [S-1:0] w_addend;
    logic [S-1:0] w_t0;
    logic [S-1:0] w_m1;
    logic [S-1:0] w_m2;
    logic [W-1:0] n_prod;
    logic [W-1:0] w_start_x;
    logic [W-1:0] w_start_y;

    // One step of the top-down shift-and-add: 2*prod + bit*x is below 3*m,
    // so at most two subtractions of m bring it back into range.
    always_comb begin
        w_addend = r_mult[W-1] ? {2'b00, r_mcand} : '0;
        w_t0     = {1'b0, r_prod, 1'b0} + w_addend;
        w_m1     = {2'b00, r_mod};
        w_m2     = {1'b0, r_mod, 1'b0};
        if (w_t0 >= w_m2) begin
            n_prod = W'(w_t0 - w_m2);
        end else if (w_t0 >= w_m1) begin
            n_prod = W'(w_t0 - w_m1);
        end else begin
            n_prod = w_t0[W-1:0];
        end
    end

    // The base is reduced as the product 1 * base, which is a plain remainder.
    always_comb begin
        unique case (i_cmd.op)
            mexp_pkg::OP_REDUCE: begin
                w_start_x = W'(1);
                w_start_y = r_base;
            end
            mexp_pkg::OP_MUL: begin
                w_start_x = r_acc;
                w_start_y = r_base;
            end
            mexp_pkg::OP_SQUARE: begin
                w_start_x = r_base;
                w_start_y = r_base;
            end
            default: begin
                w_start_x = r_base;
                w_start_y = r_base;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_in_data[W-1:0];
            r_exp  <= i_in_data[2*W-1:W];
            r_mod  <= i_in_data[3*W-1:2*W];
        end else begin
            if (i_cmd.wr_base) begin
                r_base <= n_prod;
            end
            if (i_cmd.shift_exp) begin
                r_exp <= {1'b0, r_exp[W-1:1]};
            end
        end

        if (i_cmd.start) begin
            r_prod  <= '0;
            r_mcand <= w_start_x;
            r_mult  <= w_start_y;
            r_cnt   <= mexp_pkg::LAST_BIT;
        end else if (i_cmd.step) begin
            r_prod <= n_prod;
            r_mult <= {r_mult[W-2:0], 1'b0};
            r_cnt  <= r_cnt - mexp_pkg::CNT_BITS'(1);
        end

        unique case (i_cmd.acc_sel)
            mexp_pkg::ACC_HOLD: r_acc <= r_acc;
            mexp_pkg::ACC_ONE:  r_acc <= W'(1);
            mexp_pkg::ACC_ZERO: r_acc <= '0;
            mexp_pkg::ACC_INIT: r_acc <= (r_mod == W'(1)) ? '0 : W'(1);
            mexp_pkg::ACC_PROD: r_acc <= n_prod;
            default:            r_acc <= r_acc;
        endcase

        if (i_cmd.set_res) begin
            r_res <= r_acc;
        end
    end

    always_comb begin
        o_status.exp_zero = (r_exp == '0);
        o_status.exp_lsb  = r_exp[0];
        o_status.mod_zero = (r_mod == '0);
        o_status.mul_last = (r_cnt == '0);
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ----- rtl/mexp_ctrl.sv -----
// Controller: sequences reduction, multiply and square steps and the output handshake.
`default_nettype none
module mexp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire mexp_pkg::t_status i_status,
    output mexp_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_BIT,
        ST_MUL,
        ST_SQUARE,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_tvalid;
    logic   n_m_tvalid;
    logic   w_out_free;

    assign w_out_free = !r_m_tvalid || i_m_tready;

    always_comb begin
        n_state            = r_state;
        o_cmd.load         = 1'b0;
        o_cmd.start        = 1'b0;
        o_cmd.op           = mexp_pkg::OP_SQUARE;
        o_cmd.step         = 1'b0;
        o_cmd.wr_base      = 1'b0;
        o_cmd.acc_sel      = mexp_pkg::ACC_HOLD;
        o_cmd.shift_exp    = 1'b0;
        o_cmd.set_res      = 1'b0;
        n_m_tvalid         = r_m_tvalid && !i_m_tready;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.exp_zero) begin
                    o_cmd.acc_sel = mexp_pkg::ACC_ONE;
                    n_state       = ST_FINISH;
                end else if (i_status.mod_zero) begin
                    o_cmd.acc_sel = mexp_pkg::ACC_ZERO;
                    n_state       = ST_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = mexp_pkg::OP_REDUCE;
                    n_state     = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.step = 1'b1;
                if (i_status.mul_last) begin
                    o_cmd.wr_base = 1'b1;
                    o_cmd.acc_sel = mexp_pkg::ACC_INIT;
                    n_state       = ST_BIT;
                end
            end
            ST_BIT: begin
                // Once the remaining exponent is zero no further bit changes the result.
                if (i_status.exp_zero) begin
                    n_state = ST_FINISH;
                end else if (i_status.exp_lsb) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = mexp_pkg::OP_MUL;
                    n_state     = ST_MUL;
                end else begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = mexp_pkg::OP_SQUARE;
                    n_state     = ST_SQUARE;
                end
            end
            ST_MUL: begin
                o_cmd.step = 1'b1;
                if (i_status.mul_last) begin
                    o_cmd.acc_sel = mexp_pkg::ACC_PROD;
                    n_state       = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.step = 1'b1;
                if (i_status.mul_last) begin
                    o_cmd.wr_base   = 1'b1;
                    o_cmd.shift_exp = 1'b1;
                    n_state         = ST_BIT;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    o_cmd.set_res = 1'b1;
                    n_m_tvalid    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // The square that follows a multiply is started as the multiply ends.
        if (r_state == ST_MUL && i_status.mul_last) begin
            o_cmd.start = 1'b1;
            o_cmd.op    = mexp_pkg::OP_SQUARE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;

endmodule
`default_nettype wire

// ----- rtl/modular_exponentiation_core.sv -----
// Top level of the modular exponentiation core: controller and datapath.
//
//  channel | direction | handshake              | tdata fields, lowest bit up
//  s       | in        | i_s_tvalid, o_s_tready | base, exponent, modulus (63 bits each)
//  m       | out       | o_m_tvalid, i_m_tready | power_residue (63 bits)
//
// A transaction holds the core from its accept cycle until its result is registered:
// a reduction of the base, then for each exponent bit up to the top set bit a multiply
// if the bit is set and then a square; a zero exponent or modulus skips all of these. Each
// reduction, square or multiply runs in the shared bit-serial multiplier.
// Reset clears the controller and the output valid flag only. A waiting result does
// not block the next transaction; the core stalls only if its next result is ready first.
`default_nettype none
module modular_exponentiation_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // base [62:0], exponent [125:63], modulus [188:126], zero fill
    input  wire logic [mexp_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // power_residue [62:0], zero fill
    output logic      [mexp_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    mexp_pkg::t_cmd    w_cmd;
    mexp_pkg::t_status w_status;
    logic [mexp_pkg::WORD_BITS-1:0] w_res;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mexp_datapath u_datapath (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .i_in_data (i_s_tdata),
        .o_res     (w_res)
    );

    assign o_m_tdata = mexp_pkg::OUT_TDATA_W'(w_res);

endmodule
`default_nettype wire

// ----- sim/mexp_checker.sv -----
// Checker for the modular exponentiation core: predicts each residue and compares results.
`timescale 1ns / 100ps
module mexp_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             i_s_tready,
    // base, exponent, modulus, zero fill
    input  wire logic [mexp_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                             i_m_tvalid,
    input  wire logic                             i_m_tready,
    // power_residue, zero fill
    input  wire logic [mexp_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                                    o_errors = 0,
    output int                                    o_pending = 0,
    output int                                    o_checked = 0
);

    localparam int W = mexp_pkg::WORD_BITS;
    typedef logic [W-1:0]   t_word;
    typedef logic [2*W-1:0] t_dword;

    t_word residue_q[$];

    // Square and multiply from the low exponent bit, reducing every full-width product.
    function automatic t_word residue_of(t_word base, t_word expo, t_word modulus);
        t_dword acc;
        t_dword sq;
        t_dword m;
        int     i;
        if (expo == '0) begin
            return t_word'(1);
        end
        if (modulus == '0) begin
            return '0;
        end
        m   = t_dword'(modulus);
        sq  = t_dword'(base) % m;
        acc = t_dword'(1) % m;
        for (i = 0; i < W; i++) begin
            if (expo[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (i_rst_n) begin
            // Results are matched before inputs, so one can never retire its own transaction.
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[W-1:0];
                if (residue_q.size() == 0) begin
                    $error("power_residue: expected nothing, actual %0h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = residue_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (got !== want) begin
                        $error("power_residue: expected %0h, actual %0h", want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                residue_q.insert(residue_q.size(),
                                 residue_of(i_s_tdata[W-1:0], i_s_tdata[2*W-1:W],
                                            i_s_tdata[3*W-1:2*W]));
            end
            o_pending <= residue_q.size();
        end
    end

endmodule

// ----- sim/tb_modular_exponentiation_core.sv -----
// Testbench top for the modular exponentiation core: stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module tb_modular_exponentiation_core;

    localparam int W = mexp_pkg::WORD_BITS;
    typedef logic [W-1:0] t_word;
    localparam t_word ALL_ONES = '1;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [mexp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [mexp_pkg::OUT_TDATA_W-1:0] m_tdata;

    int errors;
    int pending;
    int checked;
    int n_sent     = 0;
    int burst_left = 0;
    int unsigned stall_cycle = 0;

    modular_exponentiation_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    mexp_checker i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // The receiver cycles through steady, random, mostly-stalled and blinking stretches.
    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 1;
        case (stall_cycle[9:8])
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= stall_cycle[2];
            end
        endcase
    end

    function automatic t_word rand_word(int unsigned nbits);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (nbits >= W) begin
            return r[W-1:0];
        end
        return r[W-1:0] & ((t_word'(1) << nbits) - t_word'(1));
    endfunction

    // Valid stays high through a burst; a gap of random length follows each burst.
    task automatic send_item(input t_word base, input t_word expo, input t_word modulus);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(mexp_pkg::IN_TDATA_W - 3 * W){1'b0}}, modulus, expo, base};
        do @(posedge clk); while (!s_tready);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        t_word base;
        t_word expo;
        t_word modulus;
        int    pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero exponent gives one without reduction, whatever the modulus.
        send_item('0, '0, t_word'(1));
        send_item(t_word'(5), '0, '0);
        send_item(ALL_ONES, '0, ALL_ONES);
        // Zero modulus with a nonzero exponent gives zero.
        send_item(t_word'(7), t_word'(5), '0);
        send_item(ALL_ONES, ALL_ONES, '0);
        // The base is reduced before use.
        send_item('0, t_word'(1), t_word'(13));
        send_item(ALL_ONES, t_word'(1), ALL_ONES);
        send_item(ALL_ONES, t_word'(1), t_word'(1));
        send_item(ALL_ONES, t_word'(5), t_word'(1));
        send_item(ALL_ONES - 1, ALL_ONES, ALL_ONES);
        send_item(t_word'(2), ALL_ONES, ALL_ONES);
        send_item(t_word'(3), t_word'(1) << (W - 1), (t_word'(1) << 61) - 1);
        send_item(t_word'(1), ALL_ONES, t_word'(2));
        send_item(ALL_ONES, t_word'(2), ALL_ONES - 1);
        send_item(t_word'(1) << (W - 1), t_word'(3), (t_word'(1) << (W - 1)) + 1);
        // Moduli just above 2^31 give products just above 2^62.
        send_item(t_word'(12345), t_word'(65537), (t_word'(1) << 31) + 11);
        send_item('0, ALL_ONES, ALL_ONES);
        send_item(t_word'(2), t_word'(62), ALL_ONES);
        send_item(ALL_ONES, t_word'(3), ALL_ONES);
        drain_results();

        for (int k = 0; k < 80; k++) begin
            pick = $urandom_range(0, 9);
            modulus = rand_word($urandom_range(1, W));
            if (pick == 0) begin
                modulus = t_word'(1);
            end else if (pick == 1) begin
                modulus = ALL_ONES;
            end else if (modulus == '0) begin
                modulus = t_word'($urandom_range(1, 255));
            end

            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                base = '0;
            end else if (pick == 1) begin
                base = t_word'(1);
            end else if (pick == 2) begin
                base = modulus - 1;
            end else begin
                base = rand_word(W);
            end

            // Most exponents are short so the run stays brief; some use the full width.
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                expo = '0;
            end else if (pick < 12) begin
                expo = t_word'(1);
            end else if (pick < 28) begin
                expo = rand_word(W);
            end else begin
                expo = rand_word($urandom_range(2, 12));
            end

            // A few out-of-range zero moduli as noise.
            if ($urandom_range(0, 99) < 3) begin
                modulus = '0;
            end

            if (k == 50) begin
                drain_results();
            end
            send_item(base, expo, modulus);
        end

        drain_results();
        repeat (100) @(posedge clk);

        $display("Sent %0d transactions (corner operands, zero exponents and moduli, full-width",
                 n_sent);
        $display("exponents, output stalls) and checked %0d residues.", checked);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
